@@ src/pidl_pkg.sv @@
package pidl_pkg;

	localparam int DEPTH = 64;
	localparam int WIDTH = 32;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int CAP_W = 7;
	localparam int POS_W = 6;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_GET    = 2'd2;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_BADPOS = 2'd2;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_INS_CHK,
		S_INS_WR,
		S_DEL_RD,
		S_DEL_CAP,
		S_DEL_SRD,
		S_DEL_WR,
		S_GET_RD,
		S_GET_CAP,
		S_FIN
	} state_t;

	typedef enum logic [1:0] {
		RD_PTR,
		RD_BELOW,
		RD_ABOVE
	} rd_src_t;

	typedef struct packed {
		logic    load_op;
		logic    rd_en;
		rd_src_t rd_src;
		logic    wr_shift;
		logic    wr_value;
		logic    ptr_inc;
		logic    ptr_dec;
		logic    cap_data;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    load_result;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       refused;
		logic       ptr_gt_pos;
		logic       ptr_last;
		logic       out_free;
	} dp_stat_t;

endpackage

@@ src/pidl_ctrl.sv @@
module pidl_ctrl
	import pidl_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				if (stat.refused) begin
					state_d = S_FIN;
				end else begin
					case (stat.op)
						CMD_INSERT: state_d = S_INS_CHK;
						CMD_DELETE: state_d = S_DEL_RD;
						CMD_GET:    state_d = S_GET_RD;
						default:    state_d = S_FIN;
					endcase
				end
			end
			S_INS_CHK: state_d = stat.ptr_gt_pos ? S_INS_WR : S_FIN;
			S_INS_WR:  state_d = S_INS_CHK;
			S_DEL_RD:  state_d = S_DEL_CAP;
			S_DEL_CAP: state_d = S_DEL_WR;
			S_DEL_SRD: state_d = S_DEL_WR;
			S_DEL_WR:  state_d = stat.ptr_last ? S_FIN : S_DEL_SRD;
			S_GET_RD:  state_d = S_GET_CAP;
			S_GET_CAP: state_d = S_FIN;
			S_FIN: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.rd_src = RD_PTR;
		in_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				cmd.load_op = in_valid;
			end
			S_INS_CHK: begin
				if (stat.ptr_gt_pos) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_src = RD_BELOW;
				end else begin
					cmd.wr_value = 1'b1;
					cmd.cnt_inc  = 1'b1;
				end
			end
			S_INS_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.ptr_dec  = 1'b1;
			end
			S_DEL_RD: begin
				cmd.rd_en = 1'b1;
			end
			S_DEL_CAP: begin
				cmd.cap_data = 1'b1;
				cmd.rd_en    = 1'b1;
				cmd.rd_src   = RD_ABOVE;
			end
			S_DEL_SRD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_src = RD_ABOVE;
			end
			S_DEL_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.ptr_inc  = 1'b1;
				cmd.cnt_dec  = stat.ptr_last;
			end
			S_GET_RD: begin
				cmd.rd_en = 1'b1;
			end
			S_GET_CAP: begin
				cmd.cap_data = 1'b1;
			end
			S_FIN: begin
				cmd.load_result = stat.out_free;
			end
			default: begin
				cmd.load_op = 1'b0;
			end
		endcase
	end

endmodule

@@ src/pidl_dpath.sv @@
module pidl_dpath
	import pidl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	output dp_stat_t         stat,
	input  logic [1:0]       op_in,
	input  logic [POS_W-1:0] position,
	input  logic [WIDTH-1:0] value,
	input  logic             cfg_wr_en,
	input  logic [CAP_W-1:0] cfg_wr_data,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       status,
	output logic [WIDTH-1:0] data,
	output logic [CW-1:0]    length
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;

	logic [CAP_W-1:0] cap_q;
	logic [CW-1:0]    count_q;
	logic [1:0]       op_q;
	logic [CW-1:0]    pos_q;
	logic [CW-1:0]    ptr_q;
	logic [WIDTH-1:0] value_q;
	logic [1:0]       st_q;
	logic [WIDTH-1:0] data_q;
	logic [WIDTH-1:0] rdata_q;
	logic             rd_ok_q;
	logic             out_valid_q;
	logic [1:0]       out_status_q;
	logic [WIDTH-1:0] out_data_q;
	logic [CW-1:0]    out_length_q;

	logic [CW-1:0]    eff_cap;
	logic [CW-1:0]    pos_ext;
	logic [CW-1:0]    pos_eff;
	logic [CW-1:0]    rd_addr;
	logic [WIDTH-1:0] rdata_eff;
	logic [WIDTH-1:0] wr_data;
	logic             wr_en;
	logic [1:0]       st_d;

	// A capacity of zero behaves as one, and anything above the store size as the size.
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CW'(1);
		end else if (CW'(cap_q) > CW'(DEPTH)) begin
			eff_cap = CW'(DEPTH);
		end else begin
			eff_cap = CW'(cap_q);
		end
	end

	assign pos_ext = CW'(position);

	always_comb begin
		pos_eff = pos_ext;
		st_d    = ST_DONE;
		case (op_in)
			CMD_INSERT: begin
				if (count_q >= eff_cap) st_d = ST_FULL;
				if (pos_ext > count_q) pos_eff = count_q;
			end
			CMD_DELETE: begin
				if (pos_ext >= count_q) st_d = ST_BADPOS;
			end
			CMD_GET: begin
				if (pos_ext >= eff_cap) pos_eff = eff_cap - CW'(1);
			end
			default: begin
				st_d = ST_DONE;
			end
		endcase
	end

	always_comb begin
		case (cmd.rd_src)
			RD_BELOW: rd_addr = ptr_q - CW'(1);
			RD_ABOVE: rd_addr = ptr_q + CW'(1);
			default:  rd_addr = ptr_q;
		endcase
	end

	// Slots never written, and the slot past the end of the store, read as zero.
	assign rdata_eff = rd_ok_q ? rdata_q : '0;
	assign wr_en     = cmd.wr_shift | cmd.wr_value;
	assign wr_data   = cmd.wr_value ? value_q : rdata_eff;

	always_ff @(posedge clk) begin
		if (wr_en) mem[ptr_q[AW-1:0]] <= wr_data;
		if (cmd.rd_en) rdata_q <= mem[rd_addr[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_op) begin
			op_q    <= op_in;
			pos_q   <= pos_eff;
			value_q <= value;
			st_q    <= st_d;
		end
		if (cmd.load_op) begin
			data_q <= '0;
		end else if (cmd.cap_data) begin
			data_q <= rdata_eff;
		end
		if (cmd.load_result) begin
			out_status_q <= st_q;
			out_data_q   <= data_q;
			out_length_q <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			cap_q       <= CAP_RESET;
			count_q     <= '0;
			ptr_q       <= '0;
			rd_ok_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) cap_q <= cfg_wr_data;
			if (wr_en) valid_q[ptr_q[AW-1:0]] <= 1'b1;
			if (cmd.rd_en) begin
				rd_ok_q <= (rd_addr < CW'(DEPTH)) && valid_q[rd_addr[AW-1:0]];
			end
			if (cmd.load_op) begin
				ptr_q <= (op_in == CMD_INSERT) ? count_q : pos_eff;
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + CW'(1);
			end else if (cmd.ptr_dec) begin
				ptr_q <= ptr_q - CW'(1);
			end
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.op         = op_q;
	assign stat.refused    = (st_q != ST_DONE);
	assign stat.ptr_gt_pos = (ptr_q > pos_q);
	assign stat.ptr_last   = ((ptr_q + CW'(1)) >= count_q);
	assign stat.out_free   = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign data      = out_data_q;
	assign length    = out_length_q;

endmodule

@@ src/positional_insert_delete_list.sv @@
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall  cmd[1:0], position[5:0], value[31:0]
// out       output     out_valid/out_stall status[1:0], data[31:0], length[6:0]
// cfg       input      cfg_wr_en          cfg_wr_data[6:0] (capacity in use)
//
// One operation is in flight at a time; the list lives in a single memory with one
// read and one write per cycle, so every entry moved costs one read and one write.
// A refused beat or an unknown command goes from dispatch straight to the result. The next
// beat can be taken in the cycle after the result is loaded, and a result that waits for
// the output register to free up holds the block until the register is free.
// Reset clears the length, loads a capacity of 64 and marks every slot as never written,
// so all slots read as zero without a clearing pass.
// The finished result sits in an output register, so a new beat is taken while it waits.
module positional_insert_delete_list
	import pidl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       cmd,
	input  logic [POS_W-1:0] position,
	input  logic [WIDTH-1:0] value,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       status,
	output logic [WIDTH-1:0] data,
	output logic [CW-1:0]    length,
	input  logic             cfg_wr_en,
	input  logic [CAP_W-1:0] cfg_wr_data
);

	// The controller steps through the shift sequence for each operation; the
	// datapath holds the memory, the length, the capacity and the result register.
	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	pidl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	// An insert walks a pointer down from the end, copying each entry one slot up,
	// then drops the new word in. A delete first reads the victim, then walks up,
	// copying each entry one slot down; the old top slot takes whatever lay above it.
	pidl_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.stat        (dp_stat),
		.op_in       (cmd),
		.position    (position),
		.value       (value),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.data        (data),
		.length      (length)
	);

endmodule

@@ src/pidl_checker.sv @@
module pidl_checker
	import pidl_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [1:0]       status,
	input logic [WIDTH-1:0] data,
	input logic [CW-1:0]    length
);

	// A held result beat keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(data)
			&& $stable(length))
		else $error("result changed while stalled");

	// Only one operation is worked on at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while busy");

	a_length_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> length <= CW'(DEPTH))
		else $error("length beyond store size");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_DONE || status == ST_FULL || status == ST_BADPOS)
		else $error("undefined status");

	// A refused operation returns no data.
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_DONE |-> data == '0)
		else $error("refused operation returned data");

endmodule

bind positional_insert_delete_list pidl_checker u_pidl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.data      (data),
	.length    (length)
);

@@ dv/positional_insert_delete_list_tb.sv @@
`timescale 1ns / 1ps

// Testbench for the positional insert/delete list.
//
// The bench keeps its own copy of the list: the word store, the entry count and
// the capacity register. Every input beat that the block takes is applied to that
// copy, and the answer it gives is queued. Every output beat is then compared,
// field by field, with the oldest queued answer.
//
// The stimulus has two parts. A short directed table comes first: reset reads,
// refused operations, appends, stale slot reads, unknown commands and the capacity
// extremes. A long random part follows. It runs in phases, and each phase writes a
// new capacity and then leans toward filling, balancing or draining the list.
module positional_insert_delete_list_tb;
	import pidl_pkg::*;

	// The package names no code for the fourth command value. The block must answer
	// it as a no-op.
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;

	localparam int PHASES          = 13;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int IDLE_PCT        = 31;
	// The slowest operation moves every slot twice, once to read it and once to
	// write it. The watchdog allows that several times over, plus stall runs.
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int SETTLE_CYCLES   = 2 * DEPTH + 12;
	localparam int REPORT_LIMIT    = 10;

	localparam bit ROW_OP       = 1'b0;
	localparam bit ROW_CFG      = 1'b1;
	localparam bit PREDICTED    = 1'b0;
	localparam bit HAND_CHECKED = 1'b1;

	typedef struct packed {
		logic [1:0]       status;
		logic [WIDTH-1:0] data;
		logic [CW-1:0]    length;
	} list_result_t;

	// One line of the directed table. A configuration line carries the capacity in
	// its word field.
	typedef struct packed {
		logic             is_cfg;
		logic [1:0]       op;
		logic [POS_W-1:0] pos;
		logic [WIDTH-1:0] word;
		logic             hand;
		list_result_t     want;
	} stim_row_t;

	typedef enum int {
		MIX_FILL,
		MIX_BALANCED,
		MIX_DRAIN
	} op_mix_t;

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             in_valid    = 1'b0;
	logic             in_stall;
	logic [1:0]       cmd         = CMD_GET;
	logic [POS_W-1:0] position    = '0;
	logic [WIDTH-1:0] value       = '0;
	logic             out_valid;
	logic             out_stall   = 1'b0;
	logic [1:0]       status;
	logic [WIDTH-1:0] data;
	logic [CW-1:0]    length;
	logic             cfg_wr_en   = 1'b0;
	logic [CAP_W-1:0] cfg_wr_data = CAP_RESET;

	positional_insert_delete_list dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.position    (position),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.data        (data),
		.length      (length),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// Period of 4 ns. The stimulus moves on the falling edge, and the checks sample
	// on the rising edge, so no check races a change of an input.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// This is the bench's own copy of the list.
	logic [WIDTH-1:0] model_store [DEPTH];
	int unsigned      model_count;
	logic [CAP_W-1:0] model_cap_reg;

	list_result_t results_due [$];
	int           mismatch_count = 0;
	int           idle_pct       = IDLE_PCT;
	int           quiet_cycles   = 0;
	bit           in_beat        = 1'b0;
	bit           out_beat       = 1'b0;

	// A directed line may carry a result typed in by hand. In that case it is queued
	// instead of the computed one, but the copy of the list still advances.
	bit           hand_typed = 1'b0;
	list_result_t hand_want  = '0;

	// Applies one operation to the list copy and returns the result beat it causes.
	function automatic list_result_t apply_list_op(logic [1:0] op, logic [POS_W-1:0] pos,
			logic [WIDTH-1:0] word);
		list_result_t res;
		int unsigned  cap;
		int unsigned  slot;
		int unsigned  i;
		res  = '0;
		slot = pos;
		// A capacity of zero acts as one, and anything above the store size acts as
		// the store size.
		cap = (model_cap_reg == 0) ? 1 : ((model_cap_reg > DEPTH) ? DEPTH : model_cap_reg);
		res.status = ST_DONE;
		case (op)
			CMD_INSERT: begin
				if (model_count >= cap) begin
					res.status = ST_FULL;
				end else begin
					// A position past the end simply appends.
					if (slot > model_count)
						slot = model_count;
					for (i = model_count; i > slot; i--)
						model_store[i] = model_store[i-1];
					model_store[slot] = word;
					model_count++;
				end
			end
			CMD_DELETE: begin
				if (slot >= model_count) begin
					res.status = ST_BADPOS;
				end else begin
					res.data = model_store[slot];
					// The vacated top slot takes whatever lay just above it, and zero
					// at the very end of the store.
					for (i = slot; i < model_count; i++)
						model_store[i] = (i + 1 < DEPTH) ? model_store[i+1] : '0;
					model_count--;
				end
			end
			CMD_GET: begin
				// A get reads the slot whether it holds a live entry or not, and it is
				// clamped to the last slot the capacity allows.
				if (slot >= cap)
					slot = cap - 1;
				res.data = model_store[slot];
			end
			default: begin
			end
		endcase
		res.length = CW'(model_count);
		return res;
	endfunction

	function automatic stim_row_t stim_line(bit is_cfg, logic [1:0] op, int pos,
			logic [WIDTH-1:0] word, bit hand, logic [1:0] st, logic [WIDTH-1:0] dat,
			int len);
		stim_row_t line;
		line.is_cfg      = is_cfg;
		line.op          = op;
		line.pos         = POS_W'(pos);
		line.word        = word;
		line.hand        = hand;
		line.want.status = st;
		line.want.data   = dat;
		line.want.length = CW'(len);
		return line;
	endfunction

	// Both channels are observed on the rising edge. An input beat advances the list
	// copy and queues its answer. An output beat is checked against the oldest answer.
	// The watchdog sits at the tail and counts the edges at which neither channel
	// moves a beat.
	always @(posedge clk) begin : beat_monitor
		list_result_t predicted;
		list_result_t got;
		list_result_t want;
		in_beat  = arst_n && in_valid && !in_stall;
		out_beat = arst_n && out_valid && !out_stall;
		if (in_beat) begin
			predicted = apply_list_op(cmd, position, value);
			results_due.push_back(hand_typed ? hand_want : predicted);
		end
		if (out_beat) begin
			got = {status, data, length};
			if (results_due.size() == 0) begin
				if (mismatch_count < REPORT_LIMIT)
					$display("%0t: result with none due: status %0d data %h length %0d",
						$realtime, got.status, got.data, got.length);
				mismatch_count++;
			end else begin
				want = results_due.pop_front();
				if (got.status !== want.status || got.data !== want.data ||
						got.length !== want.length) begin
					if (mismatch_count < REPORT_LIMIT)
						$display("%0t: mismatch: status %0d/%0d data %h/%h length %0d/%0d",
							$realtime, want.status, got.status, want.data, got.data,
							want.length, got.length);
					mismatch_count++;
				end
			end
		end
		if (in_beat || out_beat)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// The receiver stalls at random, at the same rate as the sender idles.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < idle_pct);
	end

	// Presents one beat after a random number of idle cycles and returns on the
	// falling edge after the block has taken it. Valid stays high on return, so the
	// next call either lowers it or replaces the payload on that same edge.
	task automatic send_op(input logic [1:0] op, input logic [POS_W-1:0] pos,
			input logic [WIDTH-1:0] word, input bit hand, input list_result_t want);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= op;
		position   <= pos;
		value      <= word;
		hand_typed = hand;
		hand_want  = want;
		do
			@(negedge clk);
		while (!in_beat);
	endtask

	// The capacity is written only when the block is idle. Since every beat gives
	// exactly one result, the block is idle once nothing is due. The sender holds
	// off until then, and that hold-off is also how the pipeline gets fully drained.
	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= cap;
		model_cap_reg = cap;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		stim_row_t    directed_rows [$];
		stim_row_t    line;
		int           cap_plan [PHASES];
		int           cap_pick;
		int           phase;
		int           n;
		int unsigned  roll;
		int unsigned  slot;
		int unsigned  ins_cut;
		int unsigned  del_cut;
		int unsigned  get_cut;
		op_mix_t      mix;
		logic [1:0]   op;
		logic [WIDTH-1:0] word;

		cap_plan = '{64, 1, 127, 0, 2, 33, 64, -1, 7, 64, 65, -1, 64};
		for (int i = 0; i < DEPTH; i++)
			model_store[i] = '0;
		model_count   = 0;
		model_cap_reg = CAP_RESET;

		// The directed table starts from reset, with a capacity of 64 and an empty list.
		// Lines that say PREDICTED are checked against the list copy. Lines that say
		// HAND_CHECKED carry their result directly.
		// Reads after reset, a delete on an empty list and an unknown command:
		directed_rows.push_back(stim_line(ROW_OP, CMD_GET, 0, '0, HAND_CHECKED, ST_DONE, '0, 0));
		directed_rows.push_back(stim_line(ROW_OP, CMD_GET, 63, '0, HAND_CHECKED, ST_DONE, '0, 0));
		directed_rows.push_back(stim_line(ROW_OP, CMD_DELETE, 0, '0, HAND_CHECKED, ST_BADPOS, '0, 0));
		directed_rows.push_back(stim_line(ROW_OP, CMD_UNKNOWN, 63, '1, HAND_CHECKED, ST_DONE, '0, 0));
		// All-ones word at the head, then an insert far past the end, which appends.
		directed_rows.push_back(stim_line(ROW_OP, CMD_INSERT, 0, '1, HAND_CHECKED, ST_DONE, '0, 1));
		directed_rows.push_back(stim_line(ROW_OP, CMD_INSERT, 63, '0, HAND_CHECKED, ST_DONE, '0, 2));
		directed_rows.push_back(stim_line(ROW_OP, CMD_INSERT, 0, 32'hA5A5_A5A5, PREDICTED, ST_DONE, '0, 0));
		directed_rows.push_back(stim_line(ROW_OP, CMD_INSERT, 1, 32'h5A5A_5A5A, PREDICTED, ST_DONE, '0, 0));
		directed_rows.push_back(stim_line(ROW_OP, CMD_GET, 1, '0, PREDICTED, ST_DONE, '0, 0));
		// Deletes at the length and at the top position are both refused.
		directed_rows.push_back(stim_line(ROW_OP, CMD_DELETE, 4, '0, HAND_CHECKED, ST_BADPOS, '0, 4));
		directed_rows.push_back(stim_line(ROW_OP, CMD_DELETE, 63, '0, HAND_CHECKED, ST_BADPOS, '0, 4));
		directed_rows.push_back(stim_line(ROW_OP, CMD_UNKNOWN, 1, '0, HAND_CHECKED, ST_DONE, '0, 4));
		// Delete at the head. The slot just freed at the top then reads stale or zero.
		directed_rows.push_back(stim_line(ROW_OP, CMD_DELETE, 0, '0, PREDICTED, ST_DONE, '0, 0));
		directed_rows.push_back(stim_line(ROW_OP, CMD_GET, 3, '0, PREDICTED, ST_DONE, '0, 0));
		directed_rows.push_back(stim_line(ROW_OP, CMD_DELETE, 2, '0, PREDICTED, ST_DONE, '0, 0));
		directed_rows.push_back(stim_line(ROW_OP, CMD_GET, 63, '0, PREDICTED, ST_DONE, '0, 0));
		// A capacity of zero acts as one: the list is over capacity, and every get is
		// clamped to slot zero.
		directed_rows.push_back(stim_line(ROW_CFG, CMD_GET, 0, 32'd0, PREDICTED, ST_DONE, '0, 0));
		directed_rows.push_back(stim_line(ROW_OP, CMD_INSERT, 0, 32'h1234_5678, HAND_CHECKED, ST_FULL, '0, 2));
		directed_rows.push_back(stim_line(ROW_OP, CMD_GET, 40, '0, PREDICTED, ST_DONE, '0, 0));
		// The largest register value acts as the store size.
		directed_rows.push_back(stim_line(ROW_CFG, CMD_GET, 0, 32'd127, PREDICTED, ST_DONE, '0, 0));
		directed_rows.push_back(stim_line(ROW_OP, CMD_INSERT, 50, 32'hC3C3_C3C3, PREDICTED, ST_DONE, '0, 0));
		directed_rows.push_back(stim_line(ROW_OP, CMD_GET, 63, '0, PREDICTED, ST_DONE, '0, 0));
		// With a capacity below the length, an insert is refused but a delete still
		// works.
		directed_rows.push_back(stim_line(ROW_CFG, CMD_GET, 0, 32'd2, PREDICTED, ST_DONE, '0, 0));
		directed_rows.push_back(stim_line(ROW_OP, CMD_INSERT, 1, '0, HAND_CHECKED, ST_FULL, '0, 3));
		directed_rows.push_back(stim_line(ROW_OP, CMD_DELETE, 1, '0, PREDICTED, ST_DONE, '0, 0));

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			line = directed_rows[i];
			if (line.is_cfg)
				set_capacity(line.word[CAP_W-1:0]);
			else
				send_op(line.op, line.pos, line.word, line.hand, line.want);
		end

		// In the random part each phase writes a capacity, which drains the block first,
		// and then leans toward inserts, a balance, or deletes. A phase that fills the
		// list at full capacity reaches a full store, so deletes there exercise the top
		// slot being zeroed. Most deletes aim inside the list so that they take effect.
		// A phase in the middle runs without any idling on either side.
		for (phase = 0; phase < PHASES; phase++) begin
			cap_pick = (cap_plan[phase] < 0) ? $urandom_range(0, 127) : cap_plan[phase];
			set_capacity(CAP_W'(cap_pick));
			idle_pct = (phase == 6) ? 0 : IDLE_PCT;
			mix = op_mix_t'(phase % 3);
			case (mix)
				MIX_FILL: begin
					ins_cut = 75;
					del_cut = 87;
					get_cut = 97;
				end
				MIX_BALANCED: begin
					ins_cut = 40;
					del_cut = 75;
					get_cut = 97;
				end
				default: begin
					ins_cut = 15;
					del_cut = 80;
					get_cut = 97;
				end
			endcase
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < ins_cut)
					op = CMD_INSERT;
				else if (roll < del_cut)
					op = CMD_DELETE;
				else if (roll < get_cut)
					op = CMD_GET;
				else
					op = CMD_UNKNOWN;
				roll = $urandom_range(0, 99);
				if (op == CMD_DELETE && model_count != 0 && roll < 80)
					slot = $urandom_range(0, model_count - 1);
				else if (op == CMD_INSERT && roll < 50)
					slot = (model_count > DEPTH - 1) ? DEPTH - 1 : $urandom_range(0, model_count);
				else
					slot = $urandom_range(0, DEPTH - 1);
				roll = $urandom_range(0, 99);
				if (roll < 8)
					word = '0;
				else if (roll < 16)
					word = '1;
				else
					word = $urandom;
				send_op(op, POS_W'(slot), word, PREDICTED, '0);
			end
		end

		// The last beat has been taken. Wait for every answer, then watch for stray
		// output beats for about as long as the slowest operation takes.
		in_valid <= 1'b0;
		idle_pct = IDLE_PCT;
		while (results_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
